### hdl/pitb_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pitb_pkg
// Shared types and codes of the process interval timer bank.
// -----------------------------------------------------------------------------
package pitb_pkg;

   localparam int MASK_W = 16;

   typedef enum logic [1:0] {
      CMD_REAL_TICK = 2'd0,
      CMD_PROC_TICK = 2'd1,
      CMD_SET       = 2'd2,
      CMD_GET       = 2'd3
   } cmd_type;

   localparam logic [1:0] KIND_REAL    = 2'd0;
   localparam logic [1:0] KIND_VIRTUAL = 2'd1;
   localparam logic [1:0] KIND_PROF    = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic RES_EXPIRY = 1'b0;
   localparam logic RES_REPLY  = 1'b1;

   localparam logic STAT_OK      = 1'b0;
   localparam logic STAT_NO_PROC = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PICK,
      ST_EVAL,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic result_kind;
      logic [3:0] signal_process;
      logic [1:0] expired_timer;
      logic status;
      logic [31:0] old_counter;
      logic [31:0] old_interval;
      logic last;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic open;
      logic issue_read;
      logic eval;
      logic advance;
      logic flush;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic req_valid;
      logic step_valid;
      logic step_last;
      logic eval_stall;
      logic flush_done;
   } dp_stat_type;

endpackage

### hdl/pitb_req_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pitb_req_if
// Request channel: command beat into the timer bank.
// -----------------------------------------------------------------------------
interface pitb_req_if;
   logic valid;
   logic ready;
   logic [1:0] command;
   logic [3:0] process_index;
   logic [1:0] timer_kind;
   logic in_kernel;
   logic [31:0] new_counter;
   logic [31:0] new_interval;

   modport source (
      output valid, command, process_index, timer_kind, in_kernel, new_counter,
             new_interval,
      input  ready
   );
   modport sink (
      input  valid, command, process_index, timer_kind, in_kernel, new_counter,
             new_interval,
      output ready
   );
endinterface

### hdl/pitb_rsp_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pitb_rsp_if
// Response channel: expiry and reply beats out of the timer bank.
// -----------------------------------------------------------------------------
interface pitb_rsp_if;
   logic valid;
   logic ready;
   logic result_kind;
   logic [3:0] signal_process;
   logic [1:0] expired_timer;
   logic status;
   logic [31:0] old_counter;
   logic [31:0] old_interval;
   logic last;

   modport source (
      output valid, result_kind, signal_process, expired_timer, status,
             old_counter, old_interval, last,
      input  ready
   );
   modport sink (
      input  valid, result_kind, signal_process, expired_timer, status,
             old_counter, old_interval, last,
      output ready
   );
endinterface

### hdl/pitb_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pitb_ctrl
// Sequencer of the timer bank: clearing pass, step walk, final flush.
// -----------------------------------------------------------------------------
module pitb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  pitb_pkg::dp_stat_type stat,
   output pitb_pkg::ctl_cmd_type cmd
);

   pitb_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pitb_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = pitb_pkg::ST_IDLE;
         end
         pitb_pkg::ST_IDLE: begin
            if (stat.req_valid) state_in = pitb_pkg::ST_PICK;
         end
         pitb_pkg::ST_PICK: begin
            if (stat.step_valid) state_in = pitb_pkg::ST_EVAL;
            else if (stat.step_last) state_in = pitb_pkg::ST_FINAL;
         end
         pitb_pkg::ST_EVAL: begin
            if (!stat.eval_stall) begin
               state_in = stat.step_last ? pitb_pkg::ST_FINAL : pitb_pkg::ST_PICK;
            end
         end
         pitb_pkg::ST_FINAL: begin
            if (stat.flush_done) state_in = pitb_pkg::ST_IDLE;
         end
         default: state_in = pitb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         pitb_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         pitb_pkg::ST_IDLE:  cmd.open = 1'b1;
         pitb_pkg::ST_PICK: begin
            cmd.issue_read = stat.step_valid;
            cmd.advance    = !stat.step_valid && !stat.step_last;
         end
         pitb_pkg::ST_EVAL: begin
            cmd.eval    = 1'b1;
            cmd.advance = !stat.eval_stall && !stat.step_last;
         end
         pitb_pkg::ST_FINAL: cmd.flush = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pitb_pkg::ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

### hdl/pitb_datapath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pitb_datapath
// Timer store, step cursor, decrement and reload, pending and output beats.
// -----------------------------------------------------------------------------
module pitb_datapath #(
   parameter int NUM_PROCESSES = 16,
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [pitb_pkg::MASK_W-1:0] csr_write_data,
   input  pitb_pkg::ctl_cmd_type       cmd,
   output pitb_pkg::dp_stat_type       stat,
   pitb_req_if.sink                    req_chan,
   pitb_rsp_if.source                  rsp_chan
);

   localparam int CW    = COUNTER_WIDTH;
   localparam int DEPTH = 3 * NUM_PROCESSES;
   localparam int AW    = $clog2(DEPTH);
   localparam int AXW   = (AW > 6) ? AW : 6;
   localparam int WALK_N = (NUM_PROCESSES < 16) ? NUM_PROCESSES : 16;
   localparam logic [3:0] WALK_LAST = 4'(WALK_N - 1);

   logic [2*CW-1:0] mem [DEPTH];
   logic [2*CW-1:0] rd_data_ff;

   logic [pitb_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic [AW-1:0] clr_ff, clr_in;
   pitb_pkg::cmd_type cmd_ff, cmd_in;
   logic [3:0] slot_ff, slot_in;
   logic [1:0] kind_ff, kind_in;
   logic kern_ff, kern_in;
   logic [31:0] nc_ff, nc_in, ni_ff, ni_in;
   pitb_pkg::result_type pend_ff, pend_in, out_ff, out_in;
   logic pend_valid_ff, pend_valid_in, out_valid_ff, out_valid_in;

   logic accept, live, access, is_reply, produce, fire, out_free, load_out;
   logic step_valid, step_last;
   logic [AXW-1:0] addr_x;
   logic [AW-1:0] addr, wr_addr;
   logic wr_en;
   logic [2*CW-1:0] wr_data;
   logic [CW-1:0] rd_cnt, rd_int, cnt_next;
   logic expire;
   pitb_pkg::result_type new_res;

   assign accept = req_chan.valid && cmd.open;
   assign req_chan.ready = cmd.open;

   assign live   = (int'(slot_ff) < NUM_PROCESSES) && mask_ff[slot_ff];
   assign access = live && (kind_ff != pitb_pkg::KIND_UNUSED);
   assign is_reply = (cmd_ff == pitb_pkg::CMD_SET) || (cmd_ff == pitb_pkg::CMD_GET);

   assign addr_x = AXW'(slot_ff) * AXW'(3) + AXW'(kind_ff);
   assign addr   = addr_x[AW-1:0];

   assign rd_cnt = rd_data_ff[CW-1:0];
   assign rd_int = rd_data_ff[2*CW-1:CW];
   assign expire = (rd_cnt == CW'(1));
   assign cnt_next = expire ? rd_int : ((rd_cnt == '0) ? rd_cnt : rd_cnt - CW'(1));

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign produce  = is_reply || expire;
   assign stat.eval_stall = produce && pend_valid_ff && !out_free;
   assign fire = cmd.eval && !stat.eval_stall;

   always_comb begin
      case (cmd_ff)
         pitb_pkg::CMD_REAL_TICK: begin
            step_valid = live;
            step_last  = (slot_ff == WALK_LAST);
         end
         pitb_pkg::CMD_PROC_TICK: begin
            step_valid = live && ((kind_ff == pitb_pkg::KIND_PROF) || !kern_ff);
            step_last  = (kind_ff == pitb_pkg::KIND_PROF);
         end
         default: begin
            step_valid = 1'b1;
            step_last  = 1'b1;
         end
      endcase
   end

   assign stat.step_valid = step_valid;
   assign stat.step_last  = step_last;
   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign stat.req_valid  = req_chan.valid;
   assign stat.flush_done = !pend_valid_ff || out_free;

   // result built from the current step
   always_comb begin
      new_res = '0;
      new_res.signal_process = slot_ff;
      if (is_reply) begin
         new_res.result_kind = pitb_pkg::RES_REPLY;
         new_res.status      = live ? pitb_pkg::STAT_OK : pitb_pkg::STAT_NO_PROC;
         if (access) begin
            new_res.old_counter  = 32'(rd_cnt);
            new_res.old_interval = 32'(rd_int);
         end
      end else begin
         new_res.result_kind   = pitb_pkg::RES_EXPIRY;
         new_res.expired_timer = kind_ff;
         new_res.status        = pitb_pkg::STAT_OK;
      end
   end

   // store write: clearing pass, reload/decrement, or set
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr;
      wr_data = {rd_int, cnt_next};
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (fire) begin
         if (is_reply) begin
            wr_en   = (cmd_ff == pitb_pkg::CMD_SET) && access;
            wr_data = {CW'(ni_ff), CW'(nc_ff)};
         end else begin
            wr_en = (rd_cnt != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.issue_read) rd_data_ff <= mem[addr];
   end

   always_comb begin
      mask_in = csr_write_enable ? csr_write_data : mask_ff;
      clr_in  = cmd.clear_step ? clr_ff + AW'(1) : clr_ff;

      cmd_in  = cmd_ff;
      slot_in = slot_ff;
      kind_in = kind_ff;
      kern_in = kern_ff;
      nc_in   = nc_ff;
      ni_in   = ni_ff;
      if (accept) begin
         cmd_in  = pitb_pkg::cmd_type'(req_chan.command);
         kern_in = req_chan.in_kernel;
         nc_in   = req_chan.new_counter;
         ni_in   = req_chan.new_interval;
         case (pitb_pkg::cmd_type'(req_chan.command))
            pitb_pkg::CMD_REAL_TICK: begin
               slot_in = '0;
               kind_in = pitb_pkg::KIND_REAL;
            end
            pitb_pkg::CMD_PROC_TICK: begin
               slot_in = req_chan.process_index;
               kind_in = pitb_pkg::KIND_VIRTUAL;
            end
            default: begin
               slot_in = req_chan.process_index;
               kind_in = req_chan.timer_kind;
            end
         endcase
      end else if (cmd.advance) begin
         // walk slots on a real tick, timers within the slot otherwise
         if (cmd_ff == pitb_pkg::CMD_REAL_TICK) slot_in = slot_ff + 4'd1;
         else kind_in = kind_ff + 2'd1;
      end
   end

   // pending beat is held back until it is known whether it is the last one
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      load_out      = 1'b0;
      if (fire && produce) begin
         pend_in       = new_res;
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            load_out = 1'b1;
            out_in   = pend_ff;
            out_in.last = 1'b0;
         end
      end else if (cmd.flush && pend_valid_ff && out_free) begin
         pend_valid_in = 1'b0;
         load_out      = 1'b1;
         out_in        = pend_ff;
         out_in.last   = 1'b1;
      end
      out_valid_in = load_out || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= '0;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         mask_ff       <= mask_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      slot_ff <= slot_in;
      kind_ff <= kind_in;
      kern_ff <= kern_in;
      nc_ff   <= nc_in;
      ni_ff   <= ni_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.result_kind    = out_ff.result_kind;
   assign rsp_chan.signal_process = out_ff.signal_process;
   assign rsp_chan.expired_timer  = out_ff.expired_timer;
   assign rsp_chan.status         = out_ff.status;
   assign rsp_chan.old_counter    = out_ff.old_counter;
   assign rsp_chan.old_interval   = out_ff.old_interval;
   assign rsp_chan.last           = out_ff.last;

endmodule

### hdl/process_interval_timer_bank_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// process_interval_timer_bank_unit
// Three countdown timers (real, virtual, profiling) per process slot.
// -----------------------------------------------------------------------------
// Commands arrive as beats on req_chan (valid/ready); expiries and replies
// leave as beats on rsp_chan, the final beat of each command marked by last.
// csr_write_enable/csr_write_data load the live-slot mask; write it only
// while the bank is idle.
// One command is in flight at a time. A set or get reads the store, builds
// its reply beat in the pending register and then flushes it to the output
// register. A real tick walks the slots, skipping an inactive slot and, for a
// live one, reading the store, then decrementing and writing back; a final
// flush closes the walk. Each result is held one step in a pending register
// so that the last flag can be set, then moved to the output register; the
// next command is accepted while the final beat still waits.
// After reset a clearing pass writes zero to all 3*NUM_PROCESSES store
// entries, one a cycle, before the first command is taken. A stalled
// receiver holds the output beat; the walk stalls when a further result is
// ready while the pending register is full and the output beat is not yet taken.
// -----------------------------------------------------------------------------
module process_interval_timer_bank_unit #(
   parameter int NUM_PROCESSES = 16,
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [pitb_pkg::MASK_W-1:0] csr_write_data,
   pitb_req_if.sink                    req_chan,
   pitb_rsp_if.source                  rsp_chan
);

   pitb_pkg::ctl_cmd_type ctl_cmd;
   pitb_pkg::dp_stat_type dp_stat;

   pitb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (dp_stat),
      .cmd   (ctl_cmd)
   );

   pitb_datapath #(
      .NUM_PROCESSES (NUM_PROCESSES),
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (ctl_cmd),
      .stat             (dp_stat),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

endmodule
